>>> hdl/clt_pkg.sv
// ----------------------------------------------------------------------------
// Line tokenizer package
// Shared types, result kinds and character codes for the line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_TOKEN   = 3'd1,
		MODE_COMMENT = 3'd2,
		MODE_HEADER  = 3'd3,
		MODE_BODY    = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_BYTE    = 3'd0,
		KIND_TEND    = 3'd1,
		KIND_LEND    = 3'd2,
		KIND_DISCARD = 3'd3,
		KIND_TOOLONG = 3'd4
	} kind_t;

	localparam logic OP_TEXT  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam int RES_MAX = 3;

	typedef logic [1:0] rcnt_t;

	typedef struct packed {
		rcnt_t                    cnt;
		kind_t [RES_MAX-1:0]      kind;
		logic  [RES_MAX-1:0][7:0] data;
	} bundle_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_PCT  = 8'h25;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_N    = 8'h6E;
	localparam logic [7:0] CH_R    = 8'h72;
	localparam logic [7:0] CH_T    = 8'h74;

endpackage

>>> hdl/clt_front.sv
// ----------------------------------------------------------------------------
// Line tokenizer front end
// Accepts items, runs the scan state and boundary window, and builds one
// bundle of up to three results per item.
// ----------------------------------------------------------------------------
module clt_front #(
	parameter int MAX_BOUNDARY = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             op,
	input  logic [7:0]       byte_req,
	input  logic             q_full,
	output logic             push,
	output clt_pkg::bundle_t bundle
);

	localparam int CNT_W = $clog2(MAX_BOUNDARY + 1);

	clt_pkg::mode_t    mode_q, mode_d;
	logic              quote_q, quote_d;
	logic              esc_q, esc_d;
	logic              pct_q, pct_d;
	logic              lht_q, lht_d;
	logic [CNT_W-1:0]  blen_q, blen_d;
	logic [CNT_W-1:0]  wcnt_q, wcnt_d;
	logic [MAX_BOUNDARY-1:0] bmask_q, bmask_d;
	logic [MAX_BOUNDARY-1:0] bfirst_q, bfirst_d;
	logic [7:0]        bnd_q [MAX_BOUNDARY];
	logic [7:0]        win_q [MAX_BOUNDARY];

	logic              accept, flush, blank, idle_tok, tok_go;
	logic              bnd_shift, win_shift, full, match;
	logic [7:0]        bnd_in, oldest;
	logic [MAX_BOUNDARY-1:0] eq;

	clt_pkg::kind_t    tk_kind [clt_pkg::RES_MAX];
	logic [7:0]        tk_data [clt_pkg::RES_MAX];
	clt_pkg::rcnt_t    tk_cnt;
	clt_pkg::kind_t    pl_kind [2];
	logic [7:0]        pl_data [2];
	clt_pkg::rcnt_t    pl_cnt;
	logic              run_plain, tq, tesc, tpct, t_exit, t_blank;

	function automatic logic [7:0] esc_map(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			clt_pkg::CH_N: r = clt_pkg::CH_LF;
			clt_pkg::CH_R: r = clt_pkg::CH_CR;
			clt_pkg::CH_T: r = clt_pkg::CH_TAB;
			default:       r = c;
		endcase
		return r;
	endfunction

	assign accept = req_valid & ~q_full;
	assign flush  = (op == clt_pkg::OP_FLUSH);
	assign blank  = (byte_req == clt_pkg::CH_SP) || (byte_req == clt_pkg::CH_TAB);

	assign idle_tok = (byte_req != clt_pkg::CH_CR) &&
		(esc_q ? (byte_req != clt_pkg::CH_LF)
		       : !((byte_req == clt_pkg::CH_LF) || blank ||
		           (byte_req == clt_pkg::CH_HASH) || (byte_req == clt_pkg::CH_BSL) ||
		           (byte_req == clt_pkg::CH_LT)));
	assign tok_go = !flush && ((mode_q == clt_pkg::MODE_TOKEN) ||
		((mode_q == clt_pkg::MODE_IDLE) && idle_tok));

	// boundary window compare
	always_comb begin
		oldest = 8'h00;
		for (int j = 0; j < MAX_BOUNDARY; j++) begin
			eq[j]  = (win_q[j] == bnd_q[j]) | ~bmask_q[j];
			oldest = oldest | (win_q[j] & {8{bfirst_q[j]}});
		end
	end
	assign full  = (wcnt_q == blen_q);
	assign match = full & (&eq);

	// token byte handling
	always_comb begin
		pl_kind   = '{clt_pkg::KIND_BYTE, clt_pkg::KIND_BYTE};
		pl_data   = '{8'h00, 8'h00};
		pl_cnt    = '0;
		tk_kind   = '{clt_pkg::KIND_BYTE, clt_pkg::KIND_BYTE, clt_pkg::KIND_BYTE};
		tk_data   = '{8'h00, 8'h00, 8'h00};
		tk_cnt    = '0;
		tq        = quote_q;
		tesc      = esc_q;
		tpct      = pct_q;
		t_exit    = 1'b0;
		t_blank   = 1'b0;
		run_plain = 1'b0;
		if (esc_q) begin
			tesc = 1'b0;
			if (byte_req != clt_pkg::CH_LF) begin
				tk_data[0] = esc_map(byte_req);
				tk_cnt     = 2'd1;
			end
		end else begin
			if (pct_q) begin
				tpct      = 1'b0;
				run_plain = (byte_req != clt_pkg::CH_PCT);
			end else begin
				run_plain = 1'b1;
			end
			if (run_plain) begin
				if (quote_q) begin
					case (byte_req)
						clt_pkg::CH_DQ:  tq   = 1'b0;
						clt_pkg::CH_PCT: tpct = 1'b1;
						clt_pkg::CH_BSL: tesc = 1'b1;
						default: begin
							pl_data[0] = byte_req;
							pl_cnt     = 2'd1;
						end
					endcase
				end else begin
					case (byte_req)
						clt_pkg::CH_DQ:  tq   = 1'b1;
						clt_pkg::CH_PCT: tpct = 1'b1;
						clt_pkg::CH_BSL: tesc = 1'b1;
						clt_pkg::CH_SP, clt_pkg::CH_TAB: begin
							pl_kind[0] = clt_pkg::KIND_TEND;
							pl_cnt     = 2'd1;
							t_exit     = 1'b1;
							t_blank    = 1'b1;
						end
						clt_pkg::CH_LF, clt_pkg::CH_CR: begin
							pl_kind[0] = clt_pkg::KIND_TEND;
							pl_kind[1] = clt_pkg::KIND_LEND;
							pl_cnt     = 2'd2;
							t_exit     = 1'b1;
						end
						default: begin
							pl_data[0] = byte_req;
							pl_cnt     = 2'd1;
						end
					endcase
				end
			end
			if (pct_q) begin
				tk_data[0] = clt_pkg::CH_PCT;
				tk_kind[1] = pl_kind[0];
				tk_data[1] = pl_data[0];
				tk_kind[2] = pl_kind[1];
				tk_data[2] = pl_data[1];
				tk_cnt     = pl_cnt + 2'd1;
			end else begin
				tk_kind[0] = pl_kind[0];
				tk_data[0] = pl_data[0];
				tk_kind[1] = pl_kind[1];
				tk_data[1] = pl_data[1];
				tk_cnt     = pl_cnt;
			end
		end
	end

	// next state
	always_comb begin
		mode_d    = mode_q;
		quote_d   = quote_q;
		esc_d     = esc_q;
		pct_d     = pct_q;
		lht_d     = lht_q;
		blen_d    = blen_q;
		wcnt_d    = wcnt_q;
		bmask_d   = bmask_q;
		bfirst_d  = bfirst_q;
		bnd_shift = 1'b0;
		win_shift = 1'b0;
		bnd_in    = clt_pkg::CH_LF;
		if (accept) begin
			if (flush) begin
				mode_d   = clt_pkg::MODE_IDLE;
				quote_d  = 1'b0;
				esc_d    = 1'b0;
				pct_d    = 1'b0;
				lht_d    = 1'b0;
				blen_d   = '0;
				wcnt_d   = '0;
				bmask_d  = '0;
				bfirst_d = '0;
			end else begin
				case (mode_q)
					clt_pkg::MODE_TOKEN: begin
					end
					clt_pkg::MODE_COMMENT: begin
						if (byte_req == clt_pkg::CH_LF)
							mode_d = clt_pkg::MODE_IDLE;
					end
					clt_pkg::MODE_HEADER: begin
						if (byte_req == clt_pkg::CH_LF) begin
							mode_d = clt_pkg::MODE_BODY;
							wcnt_d = '0;
						end else if (!blank && (blen_q < CNT_W'(MAX_BOUNDARY))) begin
							bnd_shift = 1'b1;
							bnd_in    = byte_req;
							blen_d    = blen_q + 1'b1;
							bmask_d   = {1'b1, bmask_q[MAX_BOUNDARY-1:1]};
							bfirst_d  = {1'b0, bfirst_q[MAX_BOUNDARY-1:1]};
						end
					end
					clt_pkg::MODE_BODY: begin
						if (match) begin
							wcnt_d = '0;
							mode_d = clt_pkg::MODE_IDLE;
							lht_d  = 1'b0;
						end else begin
							win_shift = 1'b1;
							if (!full)
								wcnt_d = wcnt_q + 1'b1;
						end
					end
					default: begin
						if (byte_req != clt_pkg::CH_CR) begin
							if (esc_q) begin
								if (byte_req == clt_pkg::CH_LF)
									esc_d = 1'b0;
							end else if (byte_req == clt_pkg::CH_LF) begin
								lht_d = 1'b0;
							end else if (byte_req == clt_pkg::CH_HASH) begin
								lht_d  = 1'b0;
								mode_d = clt_pkg::MODE_COMMENT;
							end else if (byte_req == clt_pkg::CH_BSL) begin
								esc_d = 1'b1;
							end else if (byte_req == clt_pkg::CH_LT) begin
								mode_d    = clt_pkg::MODE_HEADER;
								blen_d    = CNT_W'(1);
								bnd_shift = 1'b1;
								bmask_d   = {1'b1, {(MAX_BOUNDARY-1){1'b0}}};
								bfirst_d  = {1'b1, {(MAX_BOUNDARY-1){1'b0}}};
							end
						end
					end
				endcase
				if (tok_go) begin
					quote_d = tq;
					esc_d   = tesc;
					pct_d   = tpct;
					mode_d  = t_exit ? clt_pkg::MODE_IDLE : clt_pkg::MODE_TOKEN;
					if (t_exit)
						lht_d = t_blank;
				end
			end
		end
	end

	// result bundle
	always_comb begin
		bundle = '0;
		if (accept) begin
			if (flush) begin
				if ((mode_q == clt_pkg::MODE_TOKEN) || (mode_q == clt_pkg::MODE_HEADER) ||
				    (mode_q == clt_pkg::MODE_BODY)) begin
					bundle.kind[0] = (mode_q == clt_pkg::MODE_TOKEN) ?
						clt_pkg::KIND_TEND : clt_pkg::KIND_DISCARD;
					if (lht_q || (mode_q == clt_pkg::MODE_TOKEN)) begin
						bundle.kind[1] = clt_pkg::KIND_LEND;
						bundle.cnt     = 2'd2;
					end else begin
						bundle.cnt = 2'd1;
					end
				end else if (lht_q) begin
					bundle.kind[0] = clt_pkg::KIND_LEND;
					bundle.cnt     = 2'd1;
				end
			end else if (tok_go) begin
				for (int i = 0; i < clt_pkg::RES_MAX; i++) begin
					bundle.kind[i] = tk_kind[i];
					bundle.data[i] = tk_data[i];
				end
				bundle.cnt = tk_cnt;
			end else begin
				case (mode_q)
					clt_pkg::MODE_HEADER: begin
						if ((byte_req != clt_pkg::CH_LF) && !blank &&
						    !(blen_q < CNT_W'(MAX_BOUNDARY))) begin
							bundle.kind[0] = clt_pkg::KIND_TOOLONG;
							bundle.cnt     = 2'd1;
						end
					end
					clt_pkg::MODE_BODY: begin
						if (match) begin
							bundle.kind[0] = clt_pkg::KIND_TEND;
							bundle.kind[1] = clt_pkg::KIND_LEND;
							bundle.cnt     = 2'd2;
						end else if (full) begin
							bundle.data[0] = oldest;
							bundle.cnt     = 2'd1;
						end
					end
					clt_pkg::MODE_TOKEN, clt_pkg::MODE_COMMENT: begin
					end
					default: begin
						if ((byte_req != clt_pkg::CH_CR) && !esc_q && lht_q &&
						    ((byte_req == clt_pkg::CH_LF) || (byte_req == clt_pkg::CH_HASH))) begin
							bundle.kind[0] = clt_pkg::KIND_LEND;
							bundle.cnt     = 2'd1;
						end
					end
				endcase
			end
		end
	end

	assign push = accept && (bundle.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= clt_pkg::MODE_IDLE;
			quote_q  <= 1'b0;
			esc_q    <= 1'b0;
			pct_q    <= 1'b0;
			lht_q    <= 1'b0;
			blen_q   <= '0;
			wcnt_q   <= '0;
			bmask_q  <= '0;
			bfirst_q <= '0;
		end else begin
			mode_q   <= mode_d;
			quote_q  <= quote_d;
			esc_q    <= esc_d;
			pct_q    <= pct_d;
			lht_q    <= lht_d;
			blen_q   <= blen_d;
			wcnt_q   <= wcnt_d;
			bmask_q  <= bmask_d;
			bfirst_q <= bfirst_d;
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_shift) begin
			for (int j = 0; j < MAX_BOUNDARY - 1; j++)
				bnd_q[j] <= bnd_q[j+1];
			bnd_q[MAX_BOUNDARY-1] <= bnd_in;
		end
		if (win_shift) begin
			for (int j = 0; j < MAX_BOUNDARY - 1; j++)
				win_q[j] <= win_q[j+1];
			win_q[MAX_BOUNDARY-1] <= byte_req;
		end
	end

endmodule

>>> hdl/clt_queue.sv
// ----------------------------------------------------------------------------
// Line tokenizer result queue
// Short queue of result bundles between the front and back ends.
// ----------------------------------------------------------------------------
module clt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  clt_pkg::bundle_t wdata,
	output logic             full,
	input  logic             pop,
	output clt_pkg::bundle_t head,
	output logic             nonempty
);

	clt_pkg::bundle_t               mem_q [clt_pkg::QDEPTH];
	logic [clt_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
	logic [clt_pkg::QCNT_W-1:0]     cnt_q;
	logic                           do_push, do_pop;

	assign full     = (cnt_q == clt_pkg::QCNT_W'(clt_pkg::QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rptr_q];
	assign do_push  = push & ~full;
	assign do_pop   = pop & nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= rptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

>>> hdl/clt_back.sv
// ----------------------------------------------------------------------------
// Line tokenizer back end
// Takes bundles from the queue and hands out their results one at a time.
// ----------------------------------------------------------------------------
module clt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  clt_pkg::bundle_t head,
	input  logic             nonempty,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [2:0]       kind,
	output logic [7:0]       byte_res,
	output logic             last
);

	clt_pkg::bundle_t cur_q;
	logic             cur_valid_q;
	clt_pkg::rcnt_t   idx_q;
	logic             fire, at_end, load;

	assign fire   = cur_valid_q & ~res_stall;
	assign at_end = (idx_q == (cur_q.cnt - 2'd1));
	assign load   = ~cur_valid_q | (fire & at_end);
	assign pop    = load & nonempty;

	assign res_valid = cur_valid_q;
	assign last      = at_end;

	always_comb begin
		case (idx_q)
			2'd0: begin
				kind     = cur_q.kind[0];
				byte_res = cur_q.data[0];
			end
			2'd1: begin
				kind     = cur_q.kind[1];
				byte_res = cur_q.data[1];
			end
			default: begin
				kind     = cur_q.kind[2];
				byte_res = cur_q.data[2];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			cur_valid_q <= nonempty;
			idx_q       <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			cur_q <= head;
	end

endmodule

>>> hdl/config_line_tokenizer.sv
// Path: an accepted item's bundle is written into the result queue and then loaded into
// the back end's current-bundle register, which drives res_valid and the result outputs.
// Throughput: one item per cycle while the receiver does not stall and items give at most
// one result each; larger bundles hold the output and a four-bundle queue absorbs this.
// The boundary window is compared in parallel against the stored boundary each cycle.
// Reset: asynchronous, active low; all scan state returns to idle at once.
// ----------------------------------------------------------------------------
// Config line tokenizer
// Splits a byte stream into tokens and lines, with quotes, escapes, comments
// and here-documents.
// ----------------------------------------------------------------------------
module config_line_tokenizer #(
	parameter int MAX_BOUNDARY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       op,
	input  logic [7:0] byte_req,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] kind,
	output logic [7:0] byte_res,
	output logic       last
);

	clt_pkg::bundle_t push_data, head;
	logic             push, q_full, pop, nonempty;

	assign req_stall = q_full;

	clt_front #(
		.MAX_BOUNDARY(MAX_BOUNDARY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.op       (op),
		.byte_req (byte_req),
		.q_full   (q_full),
		.push     (push),
		.bundle   (push_data)
	);

	clt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wdata   (push_data),
		.full    (q_full),
		.pop     (pop),
		.head    (head),
		.nonempty(nonempty)
	);

	clt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.nonempty (nonempty),
		.pop      (pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind     (kind),
		.byte_res (byte_res),
		.last     (last)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer testbench
// Feeds text bytes and end-of-buffer items into the tokenizer and predicts,
// item by item, the token bytes, token ends, line ends and here-document
// events it must produce. Results are checked in order, field by field,
// under random idling on both sides and a long receiver hold.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          MAX_BND      = 64;
	localparam int unsigned LONG_HOLD    = 80;
	localparam int unsigned DRAIN_TAIL   = 16;
	localparam int unsigned LIMIT_CYCLES = 400000;

	typedef struct {
		clt_pkg::kind_t kind;
		logic [7:0]     data;
		logic           last;
	} result_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic       op        = clt_pkg::OP_TEXT;
	logic [7:0] byte_req  = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [2:0] kind;
	logic [7:0] byte_res;
	logic       last;

	// tokenizer state as predicted
	clt_pkg::mode_t scan_st;
	bit             in_q, esc_p, pct_p, line_tok;
	logic [7:0]     bnd [MAX_BND];
	int unsigned    bnd_len;
	logic [7:0]     win [MAX_BND];
	int unsigned    win_cnt;

	result_t     item_results [$];
	result_t     expected_tokens [$];

	bit          src_gaps, sink_stalls, sink_hold_req;
	int unsigned items_sent, fail_count, cycle_count;

	config_line_tokenizer #(
		.MAX_BOUNDARY(MAX_BND)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.op       (op),
		.byte_req (byte_req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind     (kind),
		.byte_res (byte_res),
		.last     (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void clear_scan();
		scan_st  = clt_pkg::MODE_IDLE;
		in_q     = 1'b0;
		esc_p    = 1'b0;
		pct_p    = 1'b0;
		line_tok = 1'b0;
		bnd_len  = 0;
		win_cnt  = 0;
	endfunction

	function automatic void push_res(clt_pkg::kind_t k, logic [7:0] b);
		result_t r;
		if (item_results.size() >= clt_pkg::RES_MAX)
			return;
		r.kind = k;
		r.data = (k == clt_pkg::KIND_BYTE) ? b : 8'h00;
		r.last = 1'b0;
		item_results.insert(item_results.size(), r);
	endfunction

	function automatic void plain_char(logic [7:0] c);
		if (in_q) begin
			if (c == clt_pkg::CH_DQ)
				in_q = 1'b0;
			else if (c == clt_pkg::CH_PCT)
				pct_p = 1'b1;
			else if (c == clt_pkg::CH_BSL)
				esc_p = 1'b1;
			else
				push_res(clt_pkg::KIND_BYTE, c);
		end else if (c == clt_pkg::CH_DQ) begin
			in_q = 1'b1;
		end else if (c == clt_pkg::CH_PCT) begin
			pct_p = 1'b1;
		end else if (c == clt_pkg::CH_BSL) begin
			esc_p = 1'b1;
		end else if (c == clt_pkg::CH_SP || c == clt_pkg::CH_TAB) begin
			push_res(clt_pkg::KIND_TEND, 8'h00);
			line_tok = 1'b1;
			scan_st  = clt_pkg::MODE_IDLE;
		end else if (c == clt_pkg::CH_CR || c == clt_pkg::CH_LF) begin
			push_res(clt_pkg::KIND_TEND, 8'h00);
			push_res(clt_pkg::KIND_LEND, 8'h00);
			line_tok = 1'b0;
			scan_st  = clt_pkg::MODE_IDLE;
		end else begin
			push_res(clt_pkg::KIND_BYTE, c);
		end
	endfunction

	function automatic void token_char(logic [7:0] c);
		if (esc_p) begin
			esc_p = 1'b0;
			if (c == clt_pkg::CH_N)
				push_res(clt_pkg::KIND_BYTE, clt_pkg::CH_LF);
			else if (c == clt_pkg::CH_R)
				push_res(clt_pkg::KIND_BYTE, clt_pkg::CH_CR);
			else if (c == clt_pkg::CH_T)
				push_res(clt_pkg::KIND_BYTE, clt_pkg::CH_TAB);
			else if (c != clt_pkg::CH_LF)
				push_res(clt_pkg::KIND_BYTE, c);
		end else if (pct_p) begin
			pct_p = 1'b0;
			push_res(clt_pkg::KIND_BYTE, clt_pkg::CH_PCT);
			if (c != clt_pkg::CH_PCT)
				plain_char(c);
		end else begin
			plain_char(c);
		end
	endfunction

	function automatic void tokenize_item(logic o, logic [7:0] c);
		int unsigned blen;
		bit          hit;
		item_results.delete();
		if (o == clt_pkg::OP_FLUSH) begin
			if (scan_st == clt_pkg::MODE_TOKEN) begin
				push_res(clt_pkg::KIND_TEND, 8'h00);
				line_tok = 1'b1;
			end else if (scan_st == clt_pkg::MODE_HEADER || scan_st == clt_pkg::MODE_BODY) begin
				push_res(clt_pkg::KIND_DISCARD, 8'h00);
			end
			if (line_tok)
				push_res(clt_pkg::KIND_LEND, 8'h00);
			clear_scan();
		end else begin
			case (scan_st)
				clt_pkg::MODE_TOKEN: token_char(c);
				clt_pkg::MODE_COMMENT: begin
					if (c == clt_pkg::CH_LF)
						scan_st = clt_pkg::MODE_IDLE;
				end
				clt_pkg::MODE_HEADER: begin
					if (c == clt_pkg::CH_LF) begin
						scan_st = clt_pkg::MODE_BODY;
						win_cnt = 0;
					end else if (c == clt_pkg::CH_SP || c == clt_pkg::CH_TAB) begin
					end else if (bnd_len < MAX_BND) begin
						bnd[bnd_len] = c;
						bnd_len++;
					end else begin
						push_res(clt_pkg::KIND_TOOLONG, 8'h00);
					end
				end
				clt_pkg::MODE_BODY: begin
					blen = bnd_len;
					if (blen < 1 || blen > MAX_BND)
						blen = 1;
					if (win_cnt > blen)
						win_cnt = blen;
					hit = (win_cnt == blen);
					if (hit)
						for (int i = 0; i < blen; i++)
							if (win[i] != bnd[i])
								hit = 1'b0;
					if (hit) begin
						push_res(clt_pkg::KIND_TEND, 8'h00);
						push_res(clt_pkg::KIND_LEND, 8'h00);
						line_tok = 1'b0;
						win_cnt  = 0;
						scan_st  = clt_pkg::MODE_IDLE;
					end else if (win_cnt == blen) begin
						push_res(clt_pkg::KIND_BYTE, win[0]);
						for (int i = 0; i + 1 < blen; i++)
							win[i] = win[i + 1];
						win[blen - 1] = c;
					end else begin
						win[win_cnt] = c;
						win_cnt++;
					end
				end
				default: begin
					scan_st = clt_pkg::MODE_IDLE;
					if (c == clt_pkg::CH_CR) begin
					end else if (esc_p) begin
						if (c == clt_pkg::CH_LF) begin
							esc_p = 1'b0;
						end else begin
							scan_st = clt_pkg::MODE_TOKEN;
							token_char(c);
						end
					end else if (c == clt_pkg::CH_LF) begin
						if (line_tok) begin
							push_res(clt_pkg::KIND_LEND, 8'h00);
							line_tok = 1'b0;
						end
					end else if (c == clt_pkg::CH_SP || c == clt_pkg::CH_TAB) begin
					end else if (c == clt_pkg::CH_HASH) begin
						if (line_tok) begin
							push_res(clt_pkg::KIND_LEND, 8'h00);
							line_tok = 1'b0;
						end
						scan_st = clt_pkg::MODE_COMMENT;
					end else if (c == clt_pkg::CH_BSL) begin
						esc_p = 1'b1;
					end else if (c == clt_pkg::CH_LT) begin
						scan_st = clt_pkg::MODE_HEADER;
						bnd[0]  = clt_pkg::CH_LF;
						bnd_len = 1;
					end else begin
						scan_st = clt_pkg::MODE_TOKEN;
						token_char(c);
					end
				end
			endcase
		end
		if (item_results.size() > 0)
			item_results[item_results.size() - 1].last = 1'b1;
		foreach (item_results[i])
			expected_tokens.insert(expected_tokens.size(), item_results[i]);
	endfunction

	// receiver: random stalls, or one long hold on request
	initial begin : receiver
		int unsigned run_left;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				res_stall <= 1'b0;
				sink_hold_req = 1'b0;
				run_left = 0;
			end else begin
				if (run_left > 0)
					run_left--;
				else if (sink_stalls && $urandom_range(99) < 30)
					run_left = pick_gap();
				res_stall <= (run_left > 0);
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected result: kind %0d, byte_res %02h, last %0d",
					kind, byte_res, last);
				fail_count++;
			end else begin
				want = expected_tokens[0];
				expected_tokens.delete(0);
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					fail_count++;
				end
				if (byte_res !== want.data) begin
					$error("byte_res: expected %02h, got %02h", want.data, byte_res);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					fail_count++;
				end
			end
		end
	end

	task automatic send_item(logic o, logic [7:0] b);
		int unsigned gap;
		gap = src_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		op        <= o;
		byte_req  <= b;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
		tokenize_item(o, b);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(clt_pkg::OP_TEXT, s[i]);
	endtask

	task automatic wait_drain();
		req_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	function automatic logic [7:0] random_token_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 8'(8'h61 + $urandom_range(25));
		if (r < 63)
			return clt_pkg::CH_DQ;
		if (r < 71)
			return clt_pkg::CH_PCT;
		if (r < 79)
			return clt_pkg::CH_BSL;
		if (r < 85)
			return ($urandom_range(2) == 0) ? clt_pkg::CH_N :
				(($urandom_range(1) == 0) ? clt_pkg::CH_R : clt_pkg::CH_T);
		return 8'($urandom_range(255));
	endfunction

	task automatic send_random_line();
		int unsigned pick, n, len;
		logic [7:0]  c;
		logic [7:0]  hdr [8];
		pick = $urandom_range(99);
		if (pick < 45) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				len = $urandom_range(1, 6);
				repeat (len) send_item(clt_pkg::OP_TEXT, random_token_char());
				if ($urandom_range(9) == 0)
					send_text("\\\n");
				send_item(clt_pkg::OP_TEXT,
					($urandom_range(1) == 0) ? clt_pkg::CH_SP : clt_pkg::CH_TAB);
			end
			send_item(clt_pkg::OP_TEXT,
				($urandom_range(3) == 0) ? clt_pkg::CH_CR : clt_pkg::CH_LF);
		end else if (pick < 55) begin
			send_item(clt_pkg::OP_TEXT, clt_pkg::CH_HASH);
			repeat ($urandom_range(0, 4)) send_item(clt_pkg::OP_TEXT, random_token_char());
			send_item(clt_pkg::OP_TEXT, clt_pkg::CH_LF);
		end else if (pick < 75) begin
			send_item(clt_pkg::OP_TEXT, clt_pkg::CH_LT);
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				c = ($urandom_range(7) == 0) ? clt_pkg::CH_CR : 8'($urandom_range(8'h21, 8'h7E));
				hdr[i] = c;
				if ($urandom_range(5) == 0)
					send_item(clt_pkg::OP_TEXT,
						($urandom_range(1) == 0) ? clt_pkg::CH_SP : clt_pkg::CH_TAB);
				send_item(clt_pkg::OP_TEXT, c);
			end
			send_item(clt_pkg::OP_TEXT, clt_pkg::CH_LF);
			repeat ($urandom_range(0, 10))
				send_item(clt_pkg::OP_TEXT,
					($urandom_range(4) == 0) ? clt_pkg::CH_LF : 8'($urandom_range(255)));
			if ($urandom_range(6) != 0) begin
				send_item(clt_pkg::OP_TEXT, clt_pkg::CH_LF);
				n = len;
				for (int i = 0; i < n; i++)
					send_item(clt_pkg::OP_TEXT, hdr[i]);
				send_item(clt_pkg::OP_TEXT, 8'($urandom_range(255)));
			end
		end else if (pick < 85) begin
			send_item(clt_pkg::OP_FLUSH, 8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 6)) send_item(clt_pkg::OP_TEXT, 8'($urandom_range(255)));
		end
	endtask

	task automatic test_syntax_corners();
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		send_item(clt_pkg::OP_TEXT, 8'hFF);
		send_item(clt_pkg::OP_TEXT, clt_pkg::CH_PCT);
		send_item(clt_pkg::OP_TEXT, 8'h00);
		send_text("\" \\n\"\t\\\rt\r#x\nb\\\nc\na%");
		send_item(clt_pkg::OP_FLUSH, 8'h00);
		send_text("<\r\n\n\rk<Q");
		send_item(clt_pkg::OP_FLUSH, 8'hFF);
		wait_drain();
	endtask

	task automatic test_long_boundary();
		src_gaps    = 1'b0;
		sink_stalls = 1'b1;
		send_item(clt_pkg::OP_TEXT, clt_pkg::CH_LT);
		for (int i = 0; i < MAX_BND + 1; i++)
			send_item(clt_pkg::OP_TEXT, 8'(8'h41 + i % 26));
		send_text("\nbody");
		send_item(clt_pkg::OP_FLUSH, 8'h00);
		wait_drain();
	endtask

	task automatic test_backpressure();
		src_gaps      = 1'b0;
		sink_stalls   = 1'b0;
		sink_hold_req = 1'b1;
		for (int i = 0; i < 20; i++)
			send_item(clt_pkg::OP_TEXT, 8'(8'h61 + i % 26));
		send_text("%\r");
		wait_drain();
	endtask

	task automatic test_random_traffic(int unsigned quota, bit gaps, bit stalls);
		int unsigned target;
		src_gaps    = gaps;
		sink_stalls = stalls;
		target      = items_sent + quota;
		while (items_sent < target)
			send_random_line();
		wait_drain();
	endtask

	initial begin
		clear_scan();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_syntax_corners();
		test_long_boundary();
		test_backpressure();
		test_random_traffic(20, 1'b0, 1'b0);
		test_random_traffic(20, 1'b1, 1'b0);
		test_random_traffic(20, 1'b0, 1'b1);
		test_random_traffic(25, 1'b1, 1'b1);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
